// ===== src/lwma_pkg.sv =====
// Shared constants, types and state codes for the linear weighted moving average.
// Used by lwma_divider and linear_weighted_moving_average_top.
package lwma_pkg;

  localparam int CHANNELS   = 4;
  localparam int WINDOW_MAX = 32;
  localparam int SAMPLE_W   = 16;
  localparam int MEAN_W     = 24;
  localparam int WIN_W      = 6;
  localparam int FRAC_W     = 8;

  localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int DEN_MAX = WINDOW_MAX * (WINDOW_MAX + 1) / 2;
  localparam int DEN_W   = $clog2(DEN_MAX + 1);
  localparam int ACC_W   = SAMPLE_W + DEN_W;
  localparam int NUM_W   = ACC_W - 1 + FRAC_W;
  localparam int STEP_W  = $clog2(NUM_W + 1);

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);

  typedef logic signed [SAMPLE_W-1:0]             sample_t;
  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0]      row_t;
  typedef logic signed [ACC_W-1:0]                acc_t;
  typedef logic [NUM_W-1:0]                       num_t;
  typedef logic [DEN_W-1:0]                       den_t;
  typedef logic signed [MEAN_W-1:0]               mean_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/linear_weighted_moving_average_top.sv =====
// Linear weighted moving average over four signed 16-bit channels, Q16.8 result.
// Depends on lwma_pkg and lwma_divider.
//
// Usage:
//   Input words (in_sample_0..3) are taken when in_valid is high and in_stall low.
//   Each word is written to a 32-row history memory, then the held rows are read
//   oldest first, one row a cycle, and weighted 1..fill_count into four
//   accumulators. A shared restoring divider then produces 33 quotient bits, one
//   per cycle, for all four channels at once.
//   The history walk and the bit-serial divide set the latency from accept to
//   out_valid. The next word is taken only once the last is done, as one word is
//   in work at a time: in_stall stays high from accept until the result is
//   loaded into the output register.
//   A result word (out_mean_0..3) is held while out_stall is high; the block can
//   take the next input word while that result waits, and holds a finished
//   result internally until the output register frees.
//   cfg_wr_en writes window_length (reset 8) and restarts warm-up; write only
//   while idle. Reset clears the fill count and write slot; the history memory
//   needs no clearing as only rows written since the last restart are read.
module linear_weighted_moving_average_top import lwma_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sample_t          in_sample_0,
  input  sample_t          in_sample_1,
  input  sample_t          in_sample_2,
  input  sample_t          in_sample_3,
  output logic             out_valid,
  input  logic             out_stall,
  output mean_t            out_mean_0,
  output mean_t            out_mean_1,
  output mean_t            out_mean_2,
  output mean_t            out_mean_3,
  input  logic             cfg_wr_en,
  input  logic [WIN_W-1:0] cfg_wr_data
);

  row_t              hist_mem [WINDOW_MAX];

  state_t            state_r, state_nxt;
  logic [WIN_W-1:0]  win_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [SLOT_W-1:0] iss_slot_r, iss_slot_nxt;
  logic [CNT_W-1:0]  iss_wt_r, iss_wt_nxt;
  logic              rd_vld_r;
  logic [CNT_W-1:0]  rd_wt_r;
  row_t              rd_row_r;
  acc_t              acc_r   [CHANNELS];
  acc_t              acc_nxt [CHANNELS];
  den_t              denom_r;
  logic              neg_r   [CHANNELS];
  mean_t             mean_r  [CHANNELS];
  logic              out_valid_r, out_valid_nxt;

  logic              in_take;
  logic              issuing;
  logic              div_start;
  logic              out_room;
  logic [CNT_W-1:0]  len_w, ws_w, fc_w, fn_w, ws_inc_w, iss_inc_w;
  logic [CNT_W:0]    old_t_w, old_w;
  logic [2*CNT_W:0]  tri_w;
  row_t              in_row_w;
  num_t              div_num  [CHANNELS];
  num_t              div_quot [CHANNELS];
  acc_t              mag_w    [CHANNELS];
  acc_t              prod_w   [CHANNELS];
  logic [MEAN_W-1:0] q_w      [CHANNELS];
  div_stat_t         div_stat;

  assign in_row_w = {in_sample_3, in_sample_2, in_sample_1, in_sample_0};
  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign issuing  = (iss_wt_r <= fill_r);
  assign out_room = !out_valid_r || !out_stall;

  // window length, write slot and oldest slot of the new window
  always_comb begin
    if (win_r == '0) begin
      len_w = CNT_W'(1);
    end else if (int'(win_r) > WINDOW_MAX) begin
      len_w = CNT_W'(WINDOW_MAX);
    end else begin
      len_w = CNT_W'(win_r);
    end
    ws_w     = (CNT_W'(slot_r) >= len_w) ? '0 : CNT_W'(slot_r);
    fc_w     = (fill_r > len_w) ? len_w : fill_r;
    fn_w     = (fc_w < len_w) ? fc_w + CNT_W'(1) : fc_w;
    ws_inc_w = ws_w + CNT_W'(1);
    old_t_w  = {1'b0, ws_w} + {1'b0, len_w} + (CNT_W+1)'(1) - {1'b0, fn_w};
    old_w    = (old_t_w >= {1'b0, len_w}) ? old_t_w - {1'b0, len_w} : old_t_w;
    tri_w    = (2*CNT_W+1)'(fn_w) * ((2*CNT_W+1)'(fn_w) + (2*CNT_W+1)'(1));
    iss_inc_w = CNT_W'(iss_slot_r) + CNT_W'(1);
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      prod_w[c]  = $signed(rd_row_r[c]) * $signed({1'b0, rd_wt_r});
      acc_nxt[c] = acc_r[c] + prod_w[c];
      mag_w[c]   = acc_r[c][ACC_W-1] ? -acc_r[c] : acc_r[c];
      div_num[c] = {mag_w[c][ACC_W-2:0], FRAC_W'(0)};
      q_w[c]     = div_quot[c][MEAN_W-1:0];
    end
  end

  assign div_start = (state_r == ST_ACC) && !issuing && !rd_vld_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    iss_slot_nxt  = iss_slot_r;
    iss_wt_nxt    = iss_wt_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          slot_nxt     = (ws_inc_w == len_w) ? '0 : SLOT_W'(ws_inc_w);
          fill_nxt     = fn_w;
          iss_slot_nxt = SLOT_W'(old_w);
          iss_wt_nxt   = CNT_W'(1);
          state_nxt    = ST_ACC;
        end
      end
      ST_ACC: begin
        if (issuing) begin
          iss_wt_nxt   = iss_wt_r + CNT_W'(1);
          iss_slot_nxt = (iss_inc_w == len_w) ? '0 : SLOT_W'(iss_inc_w);
        end
        if (div_start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_room) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_wr_en) begin
      slot_nxt = '0;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= WIN_RESET;
      slot_r      <= '0;
      fill_r      <= '0;
      iss_slot_r  <= '0;
      iss_wt_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      iss_slot_r  <= iss_slot_nxt;
      iss_wt_r    <= iss_wt_nxt;
      rd_vld_r    <= (state_r == ST_ACC) && issuing;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
    end
  end

  // history memory: write the new word, read one row a cycle
  always_ff @(posedge clk) begin
    if (in_take) begin
      hist_mem[ws_w[SLOT_W-1:0]] <= in_row_w;
    end
    rd_row_r <= hist_mem[iss_slot_r];
    rd_wt_r  <= iss_wt_r;
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      denom_r <= DEN_W'(tri_w >> 1);
    end
    for (int c = 0; c < CHANNELS; c++) begin
      if (in_take) begin
        acc_r[c] <= '0;
      end else if (rd_vld_r) begin
        acc_r[c] <= acc_nxt[c];
      end
      if (div_start) begin
        neg_r[c] <= acc_r[c][ACC_W-1];
      end
      if (state_r == ST_OUT && out_room) begin
        mean_r[c] <= neg_r[c] ? $signed(MEAN_W'(0) - q_w[c]) : $signed(q_w[c]);
      end
    end
  end

  lwma_divider u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .den    (denom_r),
    .num_in (div_num),
    .quot   (div_quot),
    .stat   (div_stat)
  );

  assign out_valid  = out_valid_r;
  assign out_mean_0 = mean_r[0];
  assign out_mean_1 = mean_r[1];
  assign out_mean_2 = mean_r[2];
  assign out_mean_3 = mean_r[3];

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_w)
    else $error("fill count beyond window length");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result word raised outside output load");

  a_div_idle_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> !div_stat.busy)
    else $error("input word taken while divider busy");

endmodule

// ===== src/lwma_divider.sv =====
// Restoring divider, one quotient bit per cycle, one lane per channel.
// Depends on lwma_pkg.
module lwma_divider import lwma_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  den_t      den,
  input  num_t      num_in [CHANNELS],
  output num_t      quot   [CHANNELS],
  output div_stat_t stat
);

  num_t             num_r   [CHANNELS];
  den_t             rem_r   [CHANNELS];
  num_t             num_nxt [CHANNELS];
  den_t             rem_nxt [CHANNELS];
  logic [DEN_W:0]   trial   [CHANNELS];
  logic             fits    [CHANNELS];
  logic [STEP_W-1:0] step_r;
  logic             done_r;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      trial[c]   = {rem_r[c], num_r[c][NUM_W-1]};
      fits[c]    = trial[c] >= {1'b0, den};
      rem_nxt[c] = fits[c] ? DEN_W'(trial[c] - {1'b0, den}) : DEN_W'(trial[c]);
      num_nxt[c] = {num_r[c][NUM_W-2:0], fits[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        step_r <= STEP_W'(NUM_W);
      end else if (step_r != '0) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (start) begin
        num_r[c] <= num_in[c];
        rem_r[c] <= '0;
      end else if (step_r != '0) begin
        num_r[c] <= num_nxt[c];
        rem_r[c] <= rem_nxt[c];
      end
    end
  end

  assign quot      = num_r;
  assign stat.busy = (step_r != '0);
  assign stat.done = done_r;

endmodule
